// ===== hdl/msd_pkg.sv =====
// shared types, register codes, widths and output formatting for the sample conditioner
package msd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OS_W = 4;
    localparam int NOISE_W = 8;
    localparam int GAIN_W = 24;
    localparam int SAMPLE_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_STEREO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_16BIT  = 3'd5;

    localparam logic [OS_W-1:0] OS_RESET = 4'd2;
    localparam logic [NOISE_W-1:0] NOISE_RESET = 8'd0;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd524288;

    // datapath widths, sized for frame sums of up to 21 bits
    localparam int DC_W = 34;
    localparam int V_W = 34;
    localparam int GN_W = 43;
    localparam int GN1_W = GN_W + 1;
    localparam int GU_W = GN_W - 6;

    localparam int OUT_MIN = -32752;
    localparam int OUT_MAX = 32751;
    localparam int BYTE_OFS = 128;
    localparam int BYTE_MAX = 255;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [NOISE_W-1:0] noise;
        logic [GAIN_W-1:0]  gain;
        logic               src_stereo;
        logic               out_stereo;
        logic               out_16bit;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DC_SUM,
        ST_DC_UPD,
        ST_ADJ,
        ST_SM_MUL1,
        ST_SM_MUL2,
        ST_SM_ADD,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_GAIN,
        ST_MIX,
        ST_EMIT
    } t_bstate;

    function automatic logic [SAMPLE_W-1:0] fmt_sample(input logic signed [GN_W-1:0] v,
                                                       input logic out16);
        logic signed [GN1_W-1:0] w;
        logic signed [GU_W-1:0]  u;
        logic signed [GU_W-1:0]  c;
        logic [SAMPLE_W-1:0]     r;
        w = GN1_W'(v) + GN1_W'(BYTE_OFS);
        u = GU_W'($signed(w[GN_W:8]));
        c = u + GU_W'(BYTE_OFS);
        if (out16) begin
            if (v < GN_W'(OUT_MIN)) begin
                r = SAMPLE_W'(OUT_MIN);
            end else if (v > GN_W'(OUT_MAX)) begin
                r = SAMPLE_W'(OUT_MAX);
            end else begin
                r = v[SAMPLE_W-1:0];
            end
        end else begin
            if (c < 0) begin
                r = '0;
            end else if (c > GU_W'(BYTE_MAX)) begin
                r = SAMPLE_W'(BYTE_MAX);
            end else begin
                r = {8'd0, c[7:0]};
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/msd_front.sv =====
// front end: accepts sample pairs and sums them into frames
module msd_front
    import msd_pkg::*;
#(
    parameter int MAX_OVERSAMPLE = 8,
    parameter int ACC_W = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_os_we,
    input  logic [OS_W-1:0]            i_os_val,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_a,
    input  logic signed [SAMPLE_W-1:0] i_b,
    input  logic                       i_q_full,
    output logic                       o_push,
    output logic [2*ACC_W-1:0]         o_frame
);

    localparam int PL_W = $clog2(MAX_OVERSAMPLE + 1);

    function automatic logic [PL_W-1:0] eff_os(input logic [OS_W-1:0] v);
        logic [PL_W-1:0] r;
        if (v == '0) begin
            r = PL_W'(1);
        end else if (int'(v) > MAX_OVERSAMPLE) begin
            r = PL_W'(MAX_OVERSAMPLE);
        end else begin
            r = PL_W'(v);
        end
        return r;
    endfunction

    logic signed [ACC_W-1:0] r_acc_a;
    logic signed [ACC_W-1:0] r_acc_b;
    logic [PL_W-1:0]         r_pairs_left;
    logic [PL_W-1:0]         r_os_eff;
    logic signed [ACC_W-1:0] n_acc_a;
    logic signed [ACC_W-1:0] n_acc_b;
    logic                    w_accept;
    logic                    w_done;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign n_acc_a  = r_acc_a + ACC_W'(i_a);
    assign n_acc_b  = r_acc_b + ACC_W'(i_b);
    assign w_done   = r_pairs_left <= PL_W'(1);
    assign o_push   = w_accept && w_done;
    assign o_frame  = {n_acc_b, n_acc_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_a      <= '0;
            r_acc_b      <= '0;
            r_os_eff     <= eff_os(OS_RESET);
            r_pairs_left <= eff_os(OS_RESET);
        end else if (i_os_we) begin
            r_acc_a      <= '0;
            r_acc_b      <= '0;
            r_os_eff     <= eff_os(i_os_val);
            r_pairs_left <= eff_os(i_os_val);
        end else if (w_accept) begin
            if (w_done) begin
                r_acc_a      <= '0;
                r_acc_b      <= '0;
                r_pairs_left <= r_os_eff;
            end else begin
                r_acc_a      <= n_acc_a;
                r_acc_b      <= n_acc_b;
                r_pairs_left <= r_pairs_left - PL_W'(1);
            end
        end
    end

endmodule

// ===== hdl/msd_queue.sv =====
// short frame queue between front end and back end
module msd_queue
    import msd_pkg::*;
#(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/msd_back.sv =====
// back end: dc removal, smoothing, gain, channel mix and output register
module msd_back
    import msd_pkg::*;
#(
    parameter int ACC_W = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  logic [2*ACC_W-1:0]  i_q_data,
    output logic                o_q_pop,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [SAMPLE_W-1:0] o_m_data,
    output logic                o_m_last
);

    t_bstate r_state;
    t_bstate n_state;

    logic signed [ACC_W-1:0] r_sa;
    logic signed [ACC_W-1:0] r_sb;
    logic signed [DC_W-1:0]  r_t;
    logic [31:0]             r_dc;
    logic signed [V_W-1:0]   r_v0;
    logic signed [V_W-1:0]   r_v1;
    logic [31:0]             r_prev0;
    logic [31:0]             r_prev1;
    logic signed [43:0]      r_p1;
    logic signed [40:0]      r_p2;
    logic [V_W-1:0]          r_mag;
    logic                    r_neg;
    logic [40:0]             r_plo;
    logic [40:0]             r_phi;
    logic signed [GN_W-1:0]  r_g0;
    logic signed [GN_W-1:0]  r_g1;
    logic                    r_ch;
    logic [1:0]              r_k;
    logic [1:0]              r_last_k;
    logic                    r_dup;
    logic                    r_m_valid;
    logic [SAMPLE_W-1:0]     r_m_data;
    logic                    r_m_last;

    logic                    w_load;
    logic signed [DC_W-1:0]  w_sum;
    logic signed [DC_W-1:0]  w_t;
    logic signed [DC_W-1:0]  w_dcn;
    logic signed [32:0]      w_dc8;
    logic signed [28:0]      w_adj;
    logic signed [V_W-1:0]   w_cur;
    logic [31:0]             w_prev;
    logic [8:0]              w_keep9;
    logic signed [9:0]       w_keep;
    logic signed [8:0]       w_nz;
    logic signed [43:0]      w_p1;
    logic signed [40:0]      w_p2;
    logic signed [43:0]      w_sm;
    logic signed [V_W-1:0]   w_smv;
    logic [V_W-1:0]          w_abs;
    logic [57:0]             w_p;
    logic [41:0]             w_q;
    logic signed [GN_W-1:0]  w_gs;
    logic signed [GN1_W-1:0] w_s2;
    logic signed [GN_W-1:0]  w_avg;
    logic signed [GN_W-1:0]  w_sel;
    logic                    w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;

    assign w_sum   = DC_W'(r_sa) + DC_W'(r_sb);
    assign w_t     = (w_sum <<< 3) + DC_W'($signed(r_dc)) + DC_W'(16);
    assign w_dcn   = DC_W'($signed(r_dc)) - (r_t >>> 5);
    assign w_dc8   = 33'($signed(r_dc)) + 33'sd8;
    assign w_adj   = w_dc8[32:4];
    assign w_cur   = r_ch ? r_v1 : r_v0;
    assign w_prev  = r_ch ? r_prev1 : r_prev0;
    assign w_keep9 = 9'd256 - {1'b0, i_cfg.noise};
    assign w_keep  = {1'b0, w_keep9};
    assign w_nz    = {1'b0, i_cfg.noise};
    assign w_p1    = w_cur * w_keep;
    assign w_p2    = $signed(w_prev) * w_nz;
    assign w_sm    = r_p1 + 44'(r_p2) + 44'sd128;
    assign w_smv   = w_sm[41:8];
    assign w_abs   = w_cur[V_W-1] ? (~w_cur + V_W'(1)) : w_cur;
    assign w_p     = {17'd0, r_plo} + {r_phi, 17'd0};
    assign w_q     = w_p[57:16];
    assign w_gs    = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_s2    = GN1_W'(r_g0) + GN1_W'(r_g1) + GN1_W'(1);
    assign w_avg   = w_s2[GN_W:1];
    assign w_sel   = (r_dup ? r_k[1] : r_k[0]) ? r_g1 : r_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_DC_SUM;
                end
            end
            ST_DC_SUM: n_state = ST_DC_UPD;
            ST_DC_UPD: n_state = ST_ADJ;
            ST_ADJ: n_state = (i_cfg.noise != '0) ? ST_SM_MUL1 : ST_MAG;
            ST_SM_MUL1: n_state = ST_SM_MUL2;
            ST_SM_MUL2: n_state = ST_SM_ADD;
            ST_SM_ADD: n_state = ST_MAG;
            ST_MAG: n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_GAIN;
            ST_GAIN: begin
                if (r_ch) begin
                    n_state = ST_MIX;
                end else begin
                    n_state = (i_cfg.noise != '0) ? ST_SM_MUL1 : ST_MAG;
                end
            end
            ST_MIX: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_k == r_last_k) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc    <= '0;
            r_prev0 <= '0;
            r_prev1 <= '0;
        end else begin
            if (r_state == ST_DC_UPD) begin
                r_dc <= w_dcn[31:0];
            end
            if (r_state == ST_SM_ADD) begin
                if (r_ch) begin
                    r_prev1 <= w_smv[31:0];
                end else begin
                    r_prev0 <= w_smv[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_sa <= i_q_data[ACC_W-1:0];
                r_sb <= i_q_data[2*ACC_W-1:ACC_W];
                r_ch <= 1'b0;
            end
            ST_DC_SUM: r_t <= w_t;
            ST_ADJ: begin
                r_v0 <= V_W'(r_sa) + V_W'(w_adj);
                r_v1 <= V_W'(r_sb) + V_W'(w_adj);
            end
            ST_SM_MUL1: r_p1 <= w_p1;
            ST_SM_MUL2: r_p2 <= w_p2;
            ST_SM_ADD: begin
                if (r_ch) begin
                    r_v1 <= w_smv;
                end else begin
                    r_v0 <= w_smv;
                end
            end
            ST_MAG: begin
                r_mag <= w_abs;
                r_neg <= w_cur[V_W-1];
            end
            ST_MUL_LO: r_plo <= r_mag[16:0] * i_cfg.gain;
            ST_MUL_HI: r_phi <= r_mag[V_W-1:17] * i_cfg.gain;
            ST_GAIN: begin
                if (r_ch) begin
                    r_g1 <= w_gs;
                end else begin
                    r_g0 <= w_gs;
                end
                r_ch <= 1'b1;
            end
            ST_MIX: begin
                r_k <= 2'd0;
                if (i_cfg.src_stereo && !i_cfg.out_stereo) begin
                    r_g0     <= w_avg;
                    r_last_k <= 2'd0;
                    r_dup    <= 1'b0;
                end else if (!i_cfg.src_stereo && i_cfg.out_stereo) begin
                    r_last_k <= 2'd3;
                    r_dup    <= 1'b1;
                end else begin
                    r_last_k <= 2'd1;
                    r_dup    <= 1'b0;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    r_k <= r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= fmt_sample(w_sel, i_cfg.out_16bit);
            r_m_last <= r_k == r_last_k;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_last  = r_m_last;

endmodule

// ===== hdl/mic_sample_decimate_condition.sv =====
// top level: config registers, frame accumulator, frame queue and conditioning back end
// an input pair is accepted in any cycle in which the two-entry frame queue has room
// back end sequencer per frame: dc sum, dc update and adjust, then per channel optional smoothing
// (noise level nonzero), magnitude, two gain products and gain, then mix and one emit per result;
// it takes a new frame only after the last result of the previous one, so it sets the sustained rate
// synchronous reset clears sums, dc tracker, smoothing memories and queue, and reloads config register defaults
module mic_sample_decimate_condition
    import msd_pkg::*;
#(
    parameter int MAX_OVERSAMPLE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // sample_a, sample_b
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // out_sample
    output logic                  m_axis_tlast
);

    localparam int ACC_W = SAMPLE_W + $clog2(MAX_OVERSAMPLE + 1);

    t_cfg               r_cfg;
    logic               w_os_we;
    logic               w_push;
    logic [2*ACC_W-1:0] w_frame;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_q_pop;
    logic [2*ACC_W-1:0] w_q_data;

    assign w_os_we = i_cfg_we && (i_cfg_index == CFG_OVERSAMPLING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise      <= NOISE_RESET;
            r_cfg.gain       <= GAIN_RESET;
            r_cfg.src_stereo <= 1'b0;
            r_cfg.out_stereo <= 1'b0;
            r_cfg.out_16bit  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NOISE_LEVEL:   r_cfg.noise      <= i_cfg_data[NOISE_W-1:0];
                CFG_GAIN_Q:        r_cfg.gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_INPUT_STEREO:  r_cfg.src_stereo <= i_cfg_data[0];
                CFG_OUTPUT_STEREO: r_cfg.out_stereo <= i_cfg_data[0];
                CFG_OUTPUT_16BIT:  r_cfg.out_16bit  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    msd_front #(
        .MAX_OVERSAMPLE(MAX_OVERSAMPLE),
        .ACC_W(ACC_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_os_we(w_os_we),
        .i_os_val(i_cfg_data[OS_W-1:0]),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_a(s_axis_tdata[15:0]),
        .i_b(s_axis_tdata[31:16]),
        .i_q_full(w_q_full),
        .o_push(w_push),
        .o_frame(w_frame)
    );

    msd_queue #(
        .W(2 * ACC_W)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data(w_frame),
        .o_full(w_q_full),
        .o_valid(w_q_valid),
        .i_pop(w_q_pop),
        .o_data(w_q_data)
    );

    msd_back #(
        .ACC_W(ACC_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_q_valid(w_q_valid),
        .i_q_data(w_q_data),
        .o_q_pop(w_q_pop),
        .o_m_valid(m_axis_tvalid),
        .i_m_ready(m_axis_tready),
        .o_m_data(m_axis_tdata),
        .o_m_last(m_axis_tlast)
    );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the microphone sample decimator and conditioner
module tb;
    import msd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_OS = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PAIRS = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {RX_OPEN, RX_BUSY_LIGHT, RX_BUSY_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_out_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;   // sample_a, sample_b
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;        // out_sample
    logic                  m_axis_tlast;

    mic_sample_decimate_condition #(
        .MAX_OVERSAMPLE(MAX_OS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [3:0]  os_reg;
    logic [7:0]  noise_reg;
    logic [23:0] gain_reg;
    logic        in_st_reg;
    logic        out_st_reg;
    logic        out16_reg;
    longint      sum_l;
    longint      sum_r;
    int          pairs_rem;
    logic [31:0] dc_trk;
    logic [31:0] mem_l;
    logic [31:0] mem_r;

    t_out_word   pending_out_q[$];
    t_out_word   head_word;

    int fail_cnt = 0;
    int pairs_sent = 0;
    int words_checked = 0;
    int reg_writes = 0;

    bit tx_on = 1'b0;
    bit tx_gappy = 1'b0;
    int burst_left = 0;
    int sample_style = 0;
    int dc_base = 0;

    bit       rx_hold_req = 1'b0;
    int       rx_hold_cnt = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_cnt = 0;

    function automatic int os_eff();
        if (os_reg == 0) return 1;
        if (os_reg > MAX_OS) return MAX_OS;
        return int'(os_reg);
    endfunction

    function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_OVERSAMPLING: begin
                os_reg = d[3:0];
                sum_l = 0;
                sum_r = 0;
                pairs_rem = os_eff();
            end
            CFG_NOISE_LEVEL:   noise_reg = d[7:0];
            CFG_GAIN_Q:        gain_reg = d[23:0];
            CFG_INPUT_STEREO:  in_st_reg = d[0];
            CFG_OUTPUT_STEREO: out_st_reg = d[0];
            CFG_OUTPUT_16BIT:  out16_reg = d[0];
            default: ;
        endcase
    endfunction

    function automatic longint smooth_ch(longint s, inout logic [31:0] mem);
        longint nl;
        longint r;
        nl = longint'(noise_reg);
        r = (s * (256 - nl) + longint'($signed(mem)) * nl + 128) >>> 8;
        mem = r[31:0];
        return r;
    endfunction

    function automatic longint gain_apply(longint v);
        longint mag;
        longint p;
        mag = (v < 0) ? -v : v;
        p = (mag * longint'(gain_reg)) >>> 16;
        return (v < 0) ? -p : p;
    endfunction

    function automatic logic [15:0] fmt_word(longint v);
        longint c;
        if (out16_reg) begin
            if (v < -32752) c = -32752;
            else if (v > 32751) c = 32751;
            else c = v;
        end else begin
            c = ((v + 128) >>> 8) + 128;
            if (c < 0) c = 0;
            else if (c > 255) c = 255;
        end
        return c[15:0];
    endfunction

    function automatic void predict_pair(logic signed [15:0] a, logic signed [15:0] b);
        longint fa;
        longint fb;
        longint off;
        longint adj;
        longint v[4];
        int     n;
        sum_l += a;
        sum_r += b;
        if (pairs_rem > 1) begin
            pairs_rem--;
            return;
        end
        pairs_rem = os_eff();
        fa = sum_l;
        fb = sum_r;
        sum_l = 0;
        sum_r = 0;
        off = longint'($signed(dc_trk));
        off = off - (((fa + fb) * 8 + off + 16) >>> 5);
        dc_trk = off[31:0];
        adj = (longint'($signed(dc_trk)) + 8) >>> 4;
        fa += adj;
        fb += adj;
        if (noise_reg != 0) begin
            fa = smooth_ch(fa, mem_l);
            fb = smooth_ch(fb, mem_r);
        end
        fa = gain_apply(fa);
        fb = gain_apply(fb);
        if (in_st_reg && !out_st_reg) begin
            v[0] = (fa + fb + 1) >>> 1;
            n = 1;
        end else if (!in_st_reg && out_st_reg) begin
            v[0] = fa;
            v[1] = fa;
            v[2] = fb;
            v[3] = fb;
            n = 4;
        end else begin
            v[0] = fa;
            v[1] = fb;
            n = 2;
        end
        for (int k = 0; k < n; k++) begin
            pending_out_q.push_back('{fmt_word(v[k]), (k == n - 1)});
        end
    endfunction

    function automatic logic [15:0] pick_sample();
        int t;
        if (sample_style == 1) begin
            t = dc_base + int'($urandom_range(0, 64)) - 32;
            return t[15:0];
        end
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: begin
                t = int'($urandom_range(0, 64)) - 32;
                return t[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic do_reset();
        os_reg = OS_RESET;
        noise_reg = NOISE_RESET;
        gain_reg = GAIN_RESET;
        in_st_reg = 1'b0;
        out_st_reg = 1'b0;
        out16_reg = 1'b1;
        sum_l = 0;
        sum_r = 0;
        pairs_rem = os_eff();
        dc_trk = '0;
        mem_l = '0;
        mem_r = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_apply(idx, d);
        reg_writes++;
    endtask

    task automatic send_pair(logic [15:0] a, logic [15:0] b);
        if (!tx_on) s_axis_tvalid <= 1'b1;
        tx_on = 1'b1;
        s_axis_tdata <= {b, a};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_pair(a, b);
        pairs_sent++;
        if (tx_gappy) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                tx_on = 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        if (tx_on) begin
            s_axis_tvalid <= 1'b0;
            tx_on = 1'b0;
        end
        while (pending_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        tx_gappy = 1'b0;
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0001, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_channel_modes();
        logic [2:0] m;
        reg_write(CFG_OVERSAMPLING, 24'd1);
        reg_write(CFG_GAIN_Q, 24'd16384);
        for (int i = 0; i < 8; i++) begin
            m = 3'(i);
            reg_write(CFG_INPUT_STEREO, {23'd0, m[0]});
            reg_write(CFG_OUTPUT_STEREO, {23'd0, m[1]});
            reg_write(CFG_OUTPUT_16BIT, {23'd0, m[2]});
            send_pair(m[0] ? 16'h7FFF : 16'h8000, m[1] ? 16'h8000 : 16'h1234);
            wait_idle();
        end
    endtask

    task automatic test_smoothing_and_gain();
        reg_write(CFG_OUTPUT_16BIT, 24'd1);
        reg_write(CFG_NOISE_LEVEL, 24'd255);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        wait_idle();
        reg_write(CFG_NOISE_LEVEL, 24'd1);
        send_pair(16'd1000, 16'hFC18);
        wait_idle();
        reg_write(CFG_NOISE_LEVEL, 24'd0);
        reg_write(CFG_GAIN_Q, 24'd0);
        send_pair(16'h7FFF, 16'h7FFF);
        wait_idle();
        reg_write(CFG_GAIN_Q, 24'hFFFFFF);
        reg_write(CFG_OUTPUT_16BIT, 24'd0);
        send_pair(16'h8000, 16'd100);
        wait_idle();
    endtask

    task automatic test_oversampling_edges();
        reg_write(CFG_GAIN_Q, GAIN_RESET);
        reg_write(CFG_OUTPUT_16BIT, 24'd1);
        reg_write(CFG_OVERSAMPLING, 24'd0);
        send_pair(16'h4000, 16'hC000);
        send_pair(16'h7FFF, 16'h0000);
        wait_idle();
        // upper data bits are dropped, oversampling becomes 3
        reg_write(CFG_OVERSAMPLING, 24'hABCDE3);
        send_pair(16'h7FFF, 16'h7FFF);
        wait_idle();
        // rewrite restarts the partial frame
        reg_write(CFG_OVERSAMPLING, 24'd3);
        send_pair(16'h0100, 16'hFF00);
        send_pair(16'h2000, 16'h8000);
        send_pair(16'hFFFF, 16'h7FFF);
        wait_idle();
        reg_write(REG_SPARE_LO, 24'hFFFFFF);
        reg_write(REG_SPARE_HI, 24'h000001);
    endtask

    task automatic test_output_stall();
        reg_write(CFG_OVERSAMPLING, 24'd1);
        reg_write(CFG_INPUT_STEREO, 24'd0);
        reg_write(CFG_OUTPUT_STEREO, 24'd1);
        reg_write(CFG_GAIN_Q, 24'd4096);
        tx_gappy = 1'b0;
        sample_style = 0;
        rx_hold_req = 1'b1;
        repeat (24) send_pair(pick_sample(), pick_sample());
        wait_idle();
    endtask

    task automatic randomize_regs();
        logic [3:0] os;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) os = 4'd0;
        else if (sel == 1) os = 4'($urandom_range(9, 15));
        else if (sel == 2) os = 4'd8;
        else os = 4'($urandom_range(1, 4));
        reg_write(CFG_OVERSAMPLING, $urandom_range(0, 1) ? {20'($urandom), os} : {20'd0, os});
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0: reg_write(CFG_NOISE_LEVEL, 24'd255);
                1: reg_write(CFG_NOISE_LEVEL, {16'($urandom), 8'd1});
                2: reg_write(CFG_NOISE_LEVEL, 24'($urandom));
                default: reg_write(CFG_NOISE_LEVEL, 24'd0);
            endcase
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: reg_write(CFG_GAIN_Q, 24'd0);
                1: reg_write(CFG_GAIN_Q, 24'hFFFFFF);
                2: reg_write(CFG_GAIN_Q, GAIN_RESET);
                3, 4, 5: reg_write(CFG_GAIN_Q, 24'($urandom_range(0, 1 << 18)));
                default: reg_write(CFG_GAIN_Q, 24'($urandom_range(1 << 10, 1 << 16)));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            reg_write(CFG_INPUT_STEREO, {23'($urandom), 1'($urandom)});
        if ($urandom_range(0, 3) != 0)
            reg_write(CFG_OUTPUT_STEREO, {23'($urandom), 1'($urandom)});
        if ($urandom_range(0, 3) != 0)
            reg_write(CFG_OUTPUT_16BIT, {23'($urandom), 1'($urandom)});
        if ($urandom_range(0, 7) == 0)
            reg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
    endtask

    task automatic test_random_traffic();
        int done;
        int n;
        done = 0;
        while (done < RANDOM_PAIRS) begin
            randomize_regs();
            tx_gappy = ($urandom_range(0, 3) != 0);
            sample_style = ($urandom_range(0, 3) == 0) ? 1 : 0;
            dc_base = int'($urandom_range(0, 60000)) - 30000;
            n = $urandom_range(16, 40);
            repeat (n) send_pair(pick_sample(), pick_sample());
            done += n;
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_cnt = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_cnt == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_cnt = $urandom_range(32, 256);
            end
            rx_mode_cnt--;
            case (rx_mode)
                RX_OPEN:       m_axis_tready <= 1'b1;
                RX_BUSY_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_BUSY_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:       m_axis_tready <= ((rx_mode_cnt % 7) < 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_out_q.size() == 0) begin
                $error("unexpected word: out_sample %0d frame_last %0b",
                       $signed(m_axis_tdata), m_axis_tlast);
                fail_cnt++;
            end else begin
                head_word = pending_out_q.pop_front();
                words_checked++;
                if (m_axis_tdata !== head_word.sample) begin
                    $error("out_sample mismatch: expected %0d actual %0d",
                           $signed(head_word.sample), $signed(m_axis_tdata));
                    fail_cnt++;
                end
                if (m_axis_tlast !== head_word.last) begin
                    $error("frame_last mismatch: expected %0b actual %0b",
                           head_word.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        do_reset();
        test_reset_values();
        test_channel_modes();
        test_smoothing_and_gain();
        test_oversampling_edges();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        $display("run covered %0d sample pairs and %0d register writes", pairs_sent, reg_writes);
        $display("%0d output words checked, incl. a %0d-cycle output stall", words_checked,
                 HOLD_CYCLES);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $error("timeout with %0d words outstanding", pending_out_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
